@@ rtl/bpec_pkg.sv @@
`timescale 1ns / 1ps

package bpec_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int POS_W     = 32;
  localparam int MASS_W    = 31;
  localparam int ITEM_W    = 8 * POS_W + 4 * MASS_W;
  localparam int IN_TDATA_W  = ((ITEM_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = 8 * POS_W;
  localparam int OUT_TUSER_W = 1;

  // Center distance: 33-bit deltas, 66-bit squared sum, 33-bit root.
  localparam int DELTA_W = POS_W + 1;
  localparam int ROOT_W  = 33;
  localparam int DEPTH_W = 34;

  // Elastic formula gain (twice the other mass) and its shift amount.
  localparam int MASS_GAIN  = 2;
  localparam int MASS_SHIFT = $clog2(MASS_GAIN);

  // Working width for rescaling and saturation.
  localparam int WIDE = 72;

  // Input item, first field in the lowest bits.
  typedef struct packed {
    logic        [MASS_W-1:0] b_radius;
    logic        [MASS_W-1:0] b_mass;
    logic signed [POS_W-1:0]  b_vel_y;
    logic signed [POS_W-1:0]  b_vel_x;
    logic signed [POS_W-1:0]  b_pos_y;
    logic signed [POS_W-1:0]  b_pos_x;
    logic        [MASS_W-1:0] a_radius;
    logic        [MASS_W-1:0] a_mass;
    logic signed [POS_W-1:0]  a_vel_y;
    logic signed [POS_W-1:0]  a_vel_x;
    logic signed [POS_W-1:0]  a_pos_y;
    logic signed [POS_W-1:0]  a_pos_x;
  } item_t;

  typedef struct packed {
    logic signed [POS_W-1:0] b_new_vel_y;
    logic signed [POS_W-1:0] b_new_vel_x;
    logic signed [POS_W-1:0] b_new_pos_y;
    logic signed [POS_W-1:0] b_new_pos_x;
    logic signed [POS_W-1:0] a_new_vel_y;
    logic signed [POS_W-1:0] a_new_vel_x;
    logic signed [POS_W-1:0] a_new_pos_y;
    logic signed [POS_W-1:0] a_new_pos_x;
  } result_t;

  // Everything that rides alongside the divider.
  typedef struct packed {
    item_t                     item;
    logic signed [DEPTH_W-1:0] depth;
    logic                      hit;
    logic                      mass_nz;
    logic                      sgn_x;
    logic                      sgn_y;
  } div_side_t;

  // Divide by 2^f, truncating toward zero.
  function automatic logic signed [WIDE-1:0] qdiv(input logic signed [WIDE-1:0] v,
                                                  input int unsigned f);
    logic signed [WIDE-1:0] sh;
    logic        [WIDE-1:0] frac_mask;
    logic                   rnd;
    sh        = v >>> f;
    frac_mask = ~({WIDE{1'b1}} << f);
    rnd       = v[WIDE-1] && ((v & frac_mask) != '0);
    return sh + signed'({{(WIDE-1){1'b0}}, rnd});
  endfunction

  function automatic logic signed [POS_W-1:0] sat32(input logic signed [WIDE-1:0] v);
    logic signed [POS_W-1:0] r;
    if ((&v[WIDE-1:POS_W-1]) || !(|v[WIDE-1:POS_W-1])) begin
      r = v[POS_W-1:0];
    end else if (v[WIDE-1]) begin
      r = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(POS_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

@@ rtl/bpec_sqrt.sv @@
`timescale 1ns / 1ps

// Pipelined restoring square root: one root bit per stage.
module bpec_sqrt #(
  parameter int ROOT_W = 33,
  parameter int SIDE_W = 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [2*ROOT_W-1:0]   rad_i,
  input  logic [SIDE_W-1:0]     side_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [ROOT_W-1:0]     root_o,
  output logic [SIDE_W-1:0]     side_o
);

  logic [ROOT_W-1:0]   vld_q;
  logic [ROOT_W:0]     adv;
  logic [ROOT_W+1:0]   rem_q  [ROOT_W];
  logic [ROOT_W-1:0]   root_q [ROOT_W];
  logic [2*ROOT_W-1:0] rad_q  [ROOT_W];
  logic [SIDE_W-1:0]   side_q [ROOT_W];

  assign adv[ROOT_W] = out_ready_i;

  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    logic [ROOT_W+1:0]   rem_p, rem_sh, trial, rem_d;
    logic [ROOT_W-1:0]   root_p, root_d;
    logic [2*ROOT_W-1:0] rad_p;
    logic [SIDE_W-1:0]   side_p;
    logic                vld_p;

    if (i == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign rad_p  = rad_i;
      assign side_p = side_i;
      assign vld_p  = in_valid_i;
    end else begin : g_next
      assign rem_p  = rem_q[i-1];
      assign root_p = root_q[i-1];
      assign rad_p  = rad_q[i-1];
      assign side_p = side_q[i-1];
      assign vld_p  = vld_q[i-1];
    end

    // The partial remainder never exceeds twice the partial root, so its top
    // two bits are zero before the shift.
    assign rem_sh = {rem_p[ROOT_W-1:0], rad_p[2*ROOT_W-1 -: 2]};
    assign trial  = {root_p, 2'b01};

    always_comb begin
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_p[ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_p[ROOT_W-2:0], 1'b0};
      end
    end

    assign adv[i] = !vld_q[i] || adv[i+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (adv[i]) begin
        vld_q[i] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[i]) begin
        rem_q[i]  <= rem_d;
        root_q[i] <= root_d;
        rad_q[i]  <= {rad_p[2*ROOT_W-3:0], 2'b00};
        side_q[i] <= side_p;
      end
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = vld_q[ROOT_W-1];
  assign root_o      = root_q[ROOT_W-1];
  assign side_o      = side_q[ROOT_W-1];

endmodule

@@ rtl/bpec_div.sv @@
`timescale 1ns / 1ps

// Pipelined restoring divider, several lanes side by side, one quotient bit
// per stage. The numerator's bits above the quotient must be below the divisor.
module bpec_div #(
  parameter int LANES  = 4,
  parameter int NUM_W  = 49,
  parameter int DEN_W  = 33,
  parameter int QUOT_W = 18,
  parameter int SIDE_W = 1
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [LANES-1:0][NUM_W-1:0]        num_i,
  input  logic [LANES-1:0][DEN_W-1:0]        den_i,
  input  logic [SIDE_W-1:0]                  side_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [LANES-1:0][QUOT_W-1:0]       quot_o,
  output logic [SIDE_W-1:0]                  side_o
);

  logic [QUOT_W-1:0]                vld_q;
  logic [QUOT_W:0]                  adv;
  logic [LANES-1:0][DEN_W-1:0]      rem_q  [QUOT_W];
  logic [LANES-1:0][DEN_W-1:0]      den_q  [QUOT_W];
  logic [LANES-1:0][NUM_W-1:0]      num_q  [QUOT_W];
  logic [LANES-1:0][QUOT_W-1:0]     quot_q [QUOT_W];
  logic [SIDE_W-1:0]                side_q [QUOT_W];

  assign adv[QUOT_W] = out_ready_i;

  for (genvar i = 0; i < QUOT_W; i++) begin : g_stage
    logic [LANES-1:0][DEN_W-1:0]  rem_p, rem_d, den_p;
    logic [LANES-1:0][NUM_W-1:0]  num_p;
    logic [LANES-1:0][QUOT_W-1:0] quot_p, quot_d;
    logic [SIDE_W-1:0]            side_p;
    logic                         vld_p;

    if (i == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          rem_p[l]  = DEN_W'(num_i[l][NUM_W-1:QUOT_W]);
          quot_p[l] = '0;
        end
      end
      assign den_p  = den_i;
      assign num_p  = num_i;
      assign side_p = side_i;
      assign vld_p  = in_valid_i;
    end else begin : g_next
      assign rem_p  = rem_q[i-1];
      assign quot_p = quot_q[i-1];
      assign den_p  = den_q[i-1];
      assign num_p  = num_q[i-1];
      assign side_p = side_q[i-1];
      assign vld_p  = vld_q[i-1];
    end

    always_comb begin
      logic [DEN_W:0] rem_sh;
      logic [DEN_W:0] den_x;
      for (int l = 0; l < LANES; l++) begin
        rem_sh = {rem_p[l], num_p[l][QUOT_W-1-i]};
        den_x  = {1'b0, den_p[l]};
        if (rem_sh >= den_x) begin
          rem_d[l]  = DEN_W'(rem_sh - den_x);
          quot_d[l] = {quot_p[l][QUOT_W-2:0], 1'b1};
        end else begin
          rem_d[l]  = rem_sh[DEN_W-1:0];
          quot_d[l] = {quot_p[l][QUOT_W-2:0], 1'b0};
        end
      end
    end

    assign adv[i] = !vld_q[i] || adv[i+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (adv[i]) begin
        vld_q[i] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[i]) begin
        rem_q[i]  <= rem_d;
        quot_q[i] <= quot_d;
        den_q[i]  <= den_p;
        num_q[i]  <= num_p;
        side_q[i] <= side_p;
      end
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = vld_q[QUOT_W-1];
  assign quot_o      = quot_q[QUOT_W-1];
  assign side_o      = side_q[QUOT_W-1];

endmodule

@@ rtl/ball_pair_elastic_collision.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Payload
// s_axis    in         tdata: one circle pair (a, then b: pos x/y, vel x/y, mass, radius)
// m_axis    out        tdata: new a pos/vel, new b pos/vel; tuser: collided flag
//
// Fully pipelined: one item per cycle while m_axis accepts results, through the
// one-bit-per-stage square root (33 stages) and the one-bit-per-stage divider
// (FRACTION_BITS + 2 stages).
// Reset clears only the valid bits. A stall on m_axis holds the output
// register; stages behind it keep filling bubbles until the pipeline is full.
module ball_pair_elastic_collision #(
  parameter int FRACTION_BITS = bpec_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // a_pos_x, a_pos_y, a_vel_x, a_vel_y, a_mass, a_radius,
  // b_pos_x, b_pos_y, b_vel_x, b_vel_y, b_mass, b_radius, zero pad
  input  logic [bpec_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // a_new_pos_x, a_new_pos_y, a_new_vel_x, a_new_vel_y,
  // b_new_pos_x, b_new_pos_y, b_new_vel_x, b_new_vel_y
  output logic [bpec_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o,
  // collided
  output logic [bpec_pkg::OUT_TUSER_W-1:0]   m_axis_tuser_o
);

  import bpec_pkg::*;

  localparam int F      = FRACTION_BITS;
  localparam int UW     = F + 3;             // signed unit vector, |u| <= 2^F
  localparam int QW     = F + 2;             // quotient bits, mass ratio <= 2^(F+1)
  localparam int NW     = DELTA_W + F;       // divider numerator
  localparam int SIDE_W = $bits(div_side_t);
  localparam int PPW    = UW + DEPTH_W;      // push product
  localparam int VPW    = POS_W + UW;        // velocity projection product
  localparam int PSH_W  = 36;
  localparam int CI_W   = 35;
  localparam int DF_W   = 36;
  localparam int DA_W   = 37;
  localparam int KPW    = UW + DF_W + 1;     // mass gain product
  localparam int DPW    = DA_W + UW;         // velocity change product
  localparam int NP     = 8;                 // stages after the divider

  // ---------------- front: deltas and squared distance ----------------
  item_t                   s_item;
  logic signed [DELTA_W-1:0] s_dx, s_dy;

  logic                    t1_vld_q, t2_vld_q, t3_vld_q;
  logic                    t1_adv, t2_adv, t3_adv;
  item_t                   t1_item_q, t2_item_q;
  logic [DELTA_W-1:0]      t1_adx_q, t1_ady_q;
  logic [2*ROOT_W-1:0]     t2_rad_q;

  logic                    sq_ready, sq_vld;
  logic [ROOT_W-1:0]       sq_root;
  logic [ITEM_W-1:0]       sq_side;

  assign s_item = item_t'(s_axis_tdata_i[ITEM_W-1:0]);
  assign s_dx   = DELTA_W'(s_item.b_pos_x) - DELTA_W'(s_item.a_pos_x);
  assign s_dy   = DELTA_W'(s_item.b_pos_y) - DELTA_W'(s_item.a_pos_y);

  assign t2_adv = !t2_vld_q || sq_ready;
  assign t1_adv = !t1_vld_q || t2_adv;
  assign s_axis_tready_o = t1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_vld_q <= 1'b0;
      t2_vld_q <= 1'b0;
    end else begin
      if (t1_adv) t1_vld_q <= s_axis_tvalid_i;
      if (t2_adv) t2_vld_q <= t1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (t1_adv) begin
      t1_item_q <= s_item;
      t1_adx_q  <= s_dx[DELTA_W-1] ? DELTA_W'(-s_dx) : DELTA_W'(s_dx);
      t1_ady_q  <= s_dy[DELTA_W-1] ? DELTA_W'(-s_dy) : DELTA_W'(s_dy);
    end
    if (t2_adv) begin
      t2_item_q <= t1_item_q;
      t2_rad_q  <= (2*ROOT_W)'(t1_adx_q) * (2*ROOT_W)'(t1_adx_q)
                 + (2*ROOT_W)'(t1_ady_q) * (2*ROOT_W)'(t1_ady_q);
    end
  end

  bpec_sqrt #(
    .ROOT_W (ROOT_W),
    .SIDE_W (ITEM_W)
  ) u_sqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (t2_vld_q),
    .in_ready_o  (sq_ready),
    .rad_i       (t2_rad_q),
    .side_i      (t2_item_q),
    .out_valid_o (sq_vld),
    .out_ready_i (t3_adv),
    .root_o      (sq_root),
    .side_o      (sq_side)
  );

  // ---------------- overlap test and divider set-up ----------------
  item_t                       sq_item;
  logic signed [DELTA_W-1:0]   d3_dx, d3_dy;
  logic [DELTA_W-1:0]          d3_adx, d3_ady;
  logic signed [DEPTH_W-1:0]   d3_depth;
  logic [DELTA_W-1:0]          d3_msum;
  div_side_t                   d3_side;

  logic [3:0][NW-1:0]          t3_num_q;
  logic [3:0][DELTA_W-1:0]     t3_den_q;
  div_side_t                   t3_side_q;

  logic                        dv_ready, dv_vld;
  logic [3:0][QW-1:0]          dv_quot;
  logic [SIDE_W-1:0]           dv_side_raw;
  div_side_t                   dv_side;

  logic [NP-1:0]               p_vld_q;
  logic [NP-1:0]               p_adv;

  assign sq_item  = item_t'(sq_side);
  assign d3_dx    = DELTA_W'(sq_item.b_pos_x) - DELTA_W'(sq_item.a_pos_x);
  assign d3_dy    = DELTA_W'(sq_item.b_pos_y) - DELTA_W'(sq_item.a_pos_y);
  assign d3_adx   = d3_dx[DELTA_W-1] ? DELTA_W'(-d3_dx) : DELTA_W'(d3_dx);
  assign d3_ady   = d3_dy[DELTA_W-1] ? DELTA_W'(-d3_dy) : DELTA_W'(d3_dy);
  assign d3_depth = signed'(DEPTH_W'(sq_item.a_radius)) + signed'(DEPTH_W'(sq_item.b_radius))
                  - signed'(DEPTH_W'(sq_root));
  assign d3_msum  = DELTA_W'(sq_item.a_mass) + DELTA_W'(sq_item.b_mass);

  // Coincident centers count as no collision.
  always_comb begin
    d3_side.item    = sq_item;
    d3_side.depth   = d3_depth;
    d3_side.hit     = (sq_root != '0) && !d3_depth[DEPTH_W-1] && (d3_depth != '0);
    d3_side.mass_nz = (d3_msum != '0);
    d3_side.sgn_x   = d3_dx[DELTA_W-1];
    d3_side.sgn_y   = d3_dy[DELTA_W-1];
  end

  assign t3_adv = !t3_vld_q || dv_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t3_vld_q <= 1'b0;
    end else if (t3_adv) begin
      t3_vld_q <= sq_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (t3_adv) begin
      t3_num_q[0] <= NW'(d3_adx) << F;
      t3_num_q[1] <= NW'(d3_ady) << F;
      t3_num_q[2] <= NW'(sq_item.b_mass) << (F + MASS_SHIFT);
      t3_num_q[3] <= NW'(sq_item.a_mass) << (F + MASS_SHIFT);
      t3_den_q[0] <= DELTA_W'(sq_root);
      t3_den_q[1] <= DELTA_W'(sq_root);
      t3_den_q[2] <= d3_msum;
      t3_den_q[3] <= d3_msum;
      t3_side_q   <= d3_side;
    end
  end

  bpec_div #(
    .LANES  (4),
    .NUM_W  (NW),
    .DEN_W  (DELTA_W),
    .QUOT_W (QW),
    .SIDE_W (SIDE_W)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (t3_vld_q),
    .in_ready_o  (dv_ready),
    .num_i       (t3_num_q),
    .den_i       (t3_den_q),
    .side_i      (t3_side_q),
    .out_valid_o (dv_vld),
    .out_ready_i (p_adv[0]),
    .quot_o      (dv_quot),
    .side_o      (dv_side_raw)
  );

  assign dv_side = div_side_t'(dv_side_raw);

  // ---------------- back end: push-out and velocity update ----------------
  logic signed [UW-1:0]      pux_q [6];
  logic signed [UW-1:0]      puy_q [6];
  logic [QW-1:0]             pka_q [4];
  logic [QW-1:0]             pkb_q [4];
  item_t                     pit_q [7];
  logic                      phit_q [7];
  logic                      pmnz_q [7];
  logic signed [DEPTH_W-1:0] pdep_q;

  logic signed [PPW-1:0]     pxp_q, pyp_q;
  logic signed [VPW-1:0]     vax_q, vay_q, vbx_q, vby_q;
  logic signed [PSH_W-1:0]   pshx_q, pshy_q;
  logic signed [CI_W-1:0]    aci_q, bci_q;
  logic signed [DF_W-1:0]    pdiff_q;
  logic signed [KPW-1:0]     pa_q, pb_q;
  logic signed [DA_W-1:0]    pda_q, pdb_q;
  logic signed [DPW-1:0]     dax_q, day_q, dbx_q, dby_q;
  result_t                   out_q;
  logic                      coll_q;

  logic signed [UW-1:0]      qx_s, qy_s;
  item_t                     it3;
  logic signed [DF_W-1:0]    diff3;
  logic signed [DF_W:0]      ndiff;
  result_t                   out_d;

  always_comb begin
    p_adv[NP-1] = !p_vld_q[NP-1] || m_axis_tready_i;
    for (int k = NP - 2; k >= 0; k--) begin
      p_adv[k] = !p_vld_q[k] || p_adv[k+1];
    end
  end

  assign qx_s = signed'(UW'(dv_quot[0]));
  assign qy_s = signed'(UW'(dv_quot[1]));

  // Separation: the lighter circle moves, b on a mass tie.
  always_comb begin
    it3 = pit_q[2];
    if (phit_q[2]) begin
      if (pit_q[2].a_mass < pit_q[2].b_mass) begin
        it3.a_pos_x = sat32(WIDE'(pit_q[2].a_pos_x) - WIDE'(pshx_q));
        it3.a_pos_y = sat32(WIDE'(pit_q[2].a_pos_y) - WIDE'(pshy_q));
      end else begin
        it3.b_pos_x = sat32(WIDE'(pit_q[2].b_pos_x) + WIDE'(pshx_q));
        it3.b_pos_y = sat32(WIDE'(pit_q[2].b_pos_y) + WIDE'(pshy_q));
      end
    end
    diff3 = DF_W'(bci_q) - DF_W'(aci_q);
  end

  assign ndiff = -(signed'((DF_W+1)'(pdiff_q)));

  always_comb begin
    out_d.a_new_pos_x = pit_q[6].a_pos_x;
    out_d.a_new_pos_y = pit_q[6].a_pos_y;
    out_d.b_new_pos_x = pit_q[6].b_pos_x;
    out_d.b_new_pos_y = pit_q[6].b_pos_y;
    out_d.a_new_vel_x = pit_q[6].a_vel_x;
    out_d.a_new_vel_y = pit_q[6].a_vel_y;
    out_d.b_new_vel_x = pit_q[6].b_vel_x;
    out_d.b_new_vel_y = pit_q[6].b_vel_y;
    if (phit_q[6] && pmnz_q[6]) begin
      out_d.a_new_vel_x = sat32(WIDE'(pit_q[6].a_vel_x) + qdiv(WIDE'(dax_q), F));
      out_d.a_new_vel_y = sat32(WIDE'(pit_q[6].a_vel_y) + qdiv(WIDE'(day_q), F));
      out_d.b_new_vel_x = sat32(WIDE'(pit_q[6].b_vel_x) + qdiv(WIDE'(dbx_q), F));
      out_d.b_new_vel_y = sat32(WIDE'(pit_q[6].b_vel_y) + qdiv(WIDE'(dby_q), F));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= '0;
    end else begin
      if (p_adv[0]) p_vld_q[0] <= dv_vld;
      for (int k = 1; k < NP; k++) begin
        if (p_adv[k]) p_vld_q[k] <= p_vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    // Unit direction and mass gains.
    if (p_adv[0]) begin
      pux_q[0]  <= dv_side.sgn_x ? -qx_s : qx_s;
      puy_q[0]  <= dv_side.sgn_y ? -qy_s : qy_s;
      pka_q[0]  <= dv_quot[2];
      pkb_q[0]  <= dv_quot[3];
      pdep_q    <= dv_side.depth;
      pit_q[0]  <= dv_side.item;
      phit_q[0] <= dv_side.hit;
      pmnz_q[0] <= dv_side.mass_nz;
    end
    for (int k = 1; k < 6; k++) begin
      if (p_adv[k]) begin
        pux_q[k] <= pux_q[k-1];
        puy_q[k] <= puy_q[k-1];
      end
    end
    for (int k = 1; k < 4; k++) begin
      if (p_adv[k]) begin
        pka_q[k] <= pka_q[k-1];
        pkb_q[k] <= pkb_q[k-1];
      end
    end
    for (int k = 1; k < 7; k++) begin
      if (p_adv[k]) begin
        pit_q[k]  <= (k == 3) ? it3 : pit_q[k-1];
        phit_q[k] <= phit_q[k-1];
        pmnz_q[k] <= pmnz_q[k-1];
      end
    end
    // Push and projection products.
    if (p_adv[1]) begin
      pxp_q <= PPW'(pux_q[0]) * PPW'(pdep_q);
      pyp_q <= PPW'(puy_q[0]) * PPW'(pdep_q);
      vax_q <= VPW'(signed'(pit_q[0].a_vel_x)) * VPW'(pux_q[0]);
      vay_q <= VPW'(signed'(pit_q[0].a_vel_y)) * VPW'(puy_q[0]);
      vbx_q <= VPW'(signed'(pit_q[0].b_vel_x)) * VPW'(pux_q[0]);
      vby_q <= VPW'(signed'(pit_q[0].b_vel_y)) * VPW'(puy_q[0]);
    end
    if (p_adv[2]) begin
      pshx_q <= PSH_W'(qdiv(WIDE'(pxp_q), F));
      pshy_q <= PSH_W'(qdiv(WIDE'(pyp_q), F));
      aci_q  <= CI_W'(qdiv(WIDE'(vax_q) + WIDE'(vay_q), F));
      bci_q  <= CI_W'(qdiv(WIDE'(vbx_q) + WIDE'(vby_q), F));
    end
    if (p_adv[3]) begin
      pdiff_q <= diff3;
    end
    if (p_adv[4]) begin
      pa_q <= KPW'(signed'({1'b0, pka_q[3]})) * KPW'(pdiff_q);
      pb_q <= KPW'(signed'({1'b0, pkb_q[3]})) * KPW'(ndiff);
    end
    if (p_adv[5]) begin
      pda_q <= DA_W'(qdiv(WIDE'(pa_q), F));
      pdb_q <= DA_W'(qdiv(WIDE'(pb_q), F));
    end
    if (p_adv[6]) begin
      dax_q <= DPW'(pda_q) * DPW'(pux_q[5]);
      day_q <= DPW'(pda_q) * DPW'(puy_q[5]);
      dbx_q <= DPW'(pdb_q) * DPW'(pux_q[5]);
      dby_q <= DPW'(pdb_q) * DPW'(puy_q[5]);
    end
    if (p_adv[7]) begin
      out_q  <= out_d;
      coll_q <= phit_q[6];
    end
  end

  assign m_axis_tvalid_o = p_vld_q[NP-1];
  assign m_axis_tdata_o  = out_q;
  assign m_axis_tuser_o  = coll_q;

endmodule

@@ rtl/bpec_chk.sv @@
`timescale 1ns / 1ps

module bpec_chk (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid_i,
  input logic                              s_axis_tready_o,
  input logic [bpec_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,
  input logic                              m_axis_tvalid_o,
  input logic                              m_axis_tready_i,
  input logic [bpec_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o,
  input logic [bpec_pkg::OUT_TUSER_W-1:0]  m_axis_tuser_o
);

  import bpec_pkg::*;

  // Nothing comes out of an emptied pipeline right after reset.
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid_o)
    else $error("output valid right after reset");

  // A held result keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result changed");

  // With the output register free, every stage can move, so input is taken.
  a_empty_out_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with output register empty");

  // A downstream that takes results never throttles the input.
  a_ready_passes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready_i |-> s_axis_tready_o)
    else $error("input stalled while output is being drained");

endmodule

bind ball_pair_elastic_collision bpec_chk u_bpec_chk (.*);
